>>> hdl/fqs_pkg.sv
// types and constants shared by the fifo queue with search
// no dependencies
`default_nettype none

package fqs_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_PEEK   = 2'd3
  } fqs_action_e;

  typedef struct packed {
    fqs_action_e               action;
    logic signed [DATA_W-1:0] value;
  } fqs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic                     is_empty;
    logic                     is_full;
    logic                     error;
  } fqs_out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
  } fqs_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/fqs_cell.sv
// one storage cell of the queue chain: holds one entry and its occupied bit
// depends on fqs_pkg
`default_nettype none

module fqs_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fqs_pkg::fqs_ctrl_t               ctrl_i,
  input  logic                             prev_valid_i,
  input  logic                             next_valid_i,
  input  logic signed [fqs_pkg::DATA_W-1:0] next_data_i,
  output logic                             valid_o,
  output logic signed [fqs_pkg::DATA_W-1:0] data_o,
  output logic                             match_o
);
  import fqs_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     data_we;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    data_we = 1'b0;
    if (ctrl_i.deq) begin
      // shift toward the head
      valid_d = next_valid_i;
      data_d  = next_data_i;
      data_we = 1'b1;
    end else if (ctrl_i.enq && !valid_q && prev_valid_i) begin
      // first free cell takes the new word
      valid_d = 1'b1;
      data_d  = ctrl_i.value;
      data_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign match_o = valid_q && (data_q == ctrl_i.value);

endmodule

`default_nettype wire

>>> hdl/fifo_queue_with_search.sv
// fifo queue of signed 32-bit words with a membership search, top level
// depends on fqs_pkg and fqs_cell
//
// usage:
//   input channel in_valid_i / in_ready_o carries one request word
//   (action, value): enqueue, dequeue, search or peek at head.
//   output channel out_valid_o / out_ready_i carries one result word per
//   request: data, found, is_empty, is_full, error.
//   the queue is a chain of DEPTH cells; cell 0 is always the head. a
//   dequeue shifts every cell one place toward the head, an enqueue loads
//   the first free cell, a search compares every cell at once.
//   the result is registered when the request is accepted and held in an
//   output register.
//   throughput: one request per cycle while the receiver takes results; the
//   output register alone sets this.
//   when the receiver stalls, the result holds and in_ready_o drops until
//   it is taken; a result taken in a cycle frees room for a new request in
//   that same cycle.
//   reset clears every cell's occupied bit at once and the output valid;
//   the queue is empty and ready right after reset.
`default_nettype none

module fifo_queue_with_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fqs_pkg::fqs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fqs_pkg::fqs_out_t out_data_o
);
  import fqs_pkg::*;

  logic [DEPTH-1:0]         cell_valid;
  logic [DEPTH-1:0]         cell_match;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  fqs_ctrl_t                ctrl;

  logic     accept;
  logic     q_empty, q_full;
  fqs_out_t res_d;
  fqs_out_t out_q;
  logic     out_valid_q;

  assign q_empty    = !cell_valid[0];
  assign q_full     = cell_valid[DEPTH-1];
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign ctrl.enq   = accept && (in_data_i.action == ACT_ENQ) && !q_full;
  assign ctrl.deq   = accept && (in_data_i.action == ACT_DEQ) && !q_empty;
  assign ctrl.value = in_data_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_valid;
    logic                     next_valid;
    logic signed [DATA_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_data  = cell_data[i+1];
    end

    fqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_data_i  (next_data),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .match_o      (cell_match[i])
    );
  end

  always_comb begin
    res_d          = '0;
    res_d.is_empty = q_empty;
    res_d.is_full  = q_full;
    case (in_data_i.action)
      ACT_ENQ: begin
        res_d.error = q_full;
        if (!q_full) begin
          res_d.is_empty = 1'b0;
          res_d.is_full  = cell_valid[DEPTH-2];
        end
      end
      ACT_DEQ: begin
        res_d.error = q_empty;
        if (!q_empty) begin
          res_d.data     = cell_data[0];
          res_d.is_empty = !cell_valid[1];
          res_d.is_full  = 1'b0;
        end
      end
      ACT_SEARCH: begin
        res_d.found = |cell_match;
      end
      default: begin
        if (!q_empty) begin
          res_d.data = cell_data[0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/fqs_checker.sv
// port-level checks for the fifo queue with search, bound to the top level
// depends on fqs_pkg and fifo_queue_with_search
`default_nettype none

module fqs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input fqs_pkg::fqs_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fqs_pkg::fqs_out_t out_data_o
);
  import fqs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_empty && out_data_o.is_full))
    else $error("queue reported empty and full");

  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> !out_data_o.is_empty)
    else $error("search hit on an empty queue");

  a_error_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |->
      (out_data_o.is_empty || out_data_o.is_full) && out_data_o.data == '0)
    else $error("error without empty or full status");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> verif/fifo_queue_with_search_tb.sv
// self-checking testbench for the fifo queue with search: directed and random
// request words, a clocked driver and monitor, and a shadow queue that predicts results
// depends on fqs_pkg and fifo_queue_with_search
`default_nettype none

module fifo_queue_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fqs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned HOLD_CYCLES = 80;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fqs_in_t  in_word = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fqs_out_t out_word;

  fqs_in_t  pending_requests[$];
  fqs_out_t expected_results[$];
  logic signed [DATA_W-1:0] value_pool[$];

  logic signed [DATA_W-1:0] shadow_slots[DEPTH];
  int unsigned shadow_count = 0;
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;

  logic        in_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned search_hits = 0;
  int unsigned full_seen = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned pattern_left = 0;
  int unsigned stall_mode = 0;
  bit          hold_request = 1'b0;

  fifo_queue_with_search uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic fqs_out_t predict_queue_op(fqs_in_t req);
    fqs_out_t res;
    int unsigned idx;
    res = '0;
    case (req.action)
      ACT_ENQ: begin
        if (shadow_count >= DEPTH) begin
          res.error = 1'b1;
        end else begin
          shadow_slots[shadow_tail] = req.value;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
        end
      end
      ACT_DEQ: begin
        if (shadow_count == 0) begin
          res.error = 1'b1;
        end else begin
          res.data = shadow_slots[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      ACT_SEARCH: begin
        for (int unsigned k = 0; k < shadow_count; k++) begin
          idx = (shadow_head + k) % DEPTH;
          if (shadow_slots[idx] == req.value) res.found = 1'b1;
        end
      end
      default: begin
        if (shadow_count != 0) res.data = shadow_slots[shadow_head];
      end
    endcase
    res.is_empty = (shadow_count == 0);
    res.is_full = (shadow_count >= DEPTH);
    return res;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_request(fqs_action_e act, logic signed [DATA_W-1:0] val);
    fqs_in_t req;
    req.action = act;
    req.value = val;
    pending_requests.push_back(req);
    if (act == ACT_ENQ) begin
      value_pool.push_back(val);
      if (value_pool.size() > 32) void'(value_pool.pop_front());
    end
  endfunction

  // bias 0 fills, 1 drains, 2 mixes
  function automatic void push_random(int unsigned bias);
    int unsigned roll;
    logic signed [DATA_W-1:0] val;
    roll = $urandom_range(0, 99);
    if (value_pool.size() != 0 && $urandom_range(0, 1) == 1)
      val = value_pool[$urandom_range(0, value_pool.size() - 1)];
    else
      val = pick_value();
    case (bias)
      0: roll = (roll < 60) ? 0 : (roll < 75) ? 1 : (roll < 90) ? 2 : 3;
      1: roll = (roll < 15) ? 0 : (roll < 75) ? 1 : (roll < 90) ? 2 : 3;
      default: roll = (roll < 35) ? 0 : (roll < 65) ? 1 : (roll < 85) ? 2 : 3;
    endcase
    case (roll)
      0: push_request(ACT_ENQ, pick_value());
      1: push_request(ACT_DEQ, val);
      2: push_request(ACT_SEARCH, val);
      default: push_request(ACT_PEEK, val);
    endcase
  endfunction

  task automatic drain_all();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : driver
    logic    nxt_valid;
    fqs_in_t nxt_word;
    nxt_valid = in_valid;
    nxt_word = in_word;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_word = pending_requests.pop_front();
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid <= nxt_valid;
    in_word <= nxt_word;
  end

  always @(negedge clk_i) begin : receiver
    logic nxt_ready;
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(16, 64);
      stall_mode = $urandom_range(0, 3);
    end else begin
      pattern_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      case (stall_mode)
        0: nxt_ready = 1'b1;
        1: nxt_ready = $urandom_range(0, 1);
        2: nxt_ready = ($urandom_range(0, 3) == 0);
        default: nxt_ready = cycle_count[0];
      endcase
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk_i) begin : monitor
    fqs_out_t want;
    cycle_count++;
    in_taken <= rst_ni && in_valid && in_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        words_out++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, out_word);
        end else begin
          want = expected_results.pop_front();
          check_field("data", want.data, out_word.data);
          check_field("found", want.found, out_word.found);
          check_field("is_empty", want.is_empty, out_word.is_empty);
          check_field("is_full", want.is_full, out_word.is_full);
          check_field("error", want.error, out_word.error);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_queue_op(in_word);
        expected_results.push_back(want);
        words_in++;
        if (want.error && want.is_full) full_rejects++;
        if (want.error && want.is_empty) empty_rejects++;
        if (want.found) search_hits++;
        if (want.is_full) full_seen++;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned seg;
    int unsigned seg_len;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_request(ACT_PEEK, 32'sd5);
    push_request(ACT_DEQ, 32'sd7);
    push_request(ACT_SEARCH, '0);
    push_request(ACT_ENQ, 32'sh7fffffff);
    push_request(ACT_ENQ, 32'sh80000000);
    push_request(ACT_ENQ, '0);
    push_request(ACT_ENQ, '1);
    repeat (DEPTH - 4) push_request(ACT_ENQ, $urandom);
    push_request(ACT_ENQ, 32'sd99);
    push_request(ACT_SEARCH, 32'sh80000000);
    push_request(ACT_SEARCH, 32'sd99);
    push_request(ACT_PEEK, '1);
    push_request(ACT_DEQ, '0);
    push_request(ACT_DEQ, '0);
    drain_all();

    seg = 0;
    while (pending_requests.size() + words_in < RANDOM_WORDS + 25) begin
      if (seg == 3) begin
        hold_request = 1'b1;
        repeat (40) push_random(0);
      end
      if (seg == 10) drain_all();
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) push_random(seg % 3);
      seg++;
      while (pending_requests.size() > 100) @(posedge clk_i);
    end
    drain_all();
    repeat (4) @(posedge clk_i);

    $display("%0d requests, %0d results; %0d rejected on full, %0d on empty,",
             words_in, words_out, full_rejects, empty_rejects);
    $display("%0d search hits, %0d results with the queue full", search_hits, full_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
